/* sv/pfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Frame table entry layout, command, state and status codes, result word.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_FRAMES    = 1024;
  localparam int AW            = $clog2(MAX_FRAMES);
  localparam int CW            = AW + 1;
  localparam int MAX_RUN       = 16;
  localparam int VICTIM_STRIDE = 5;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_KALLOC = 3'd1,
    CMD_UALLOC = 3'd2,
    CMD_UFREE  = 3'd3,
    CMD_KFREE  = 3'd4,
    CMD_CLEAN  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    FS_FREE  = 2'd0,
    FS_FIXED = 2'd1,
    FS_CLEAN = 2'd2,
    FS_DIRTY = 2'd3
  } fstate_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_OOM   = 2'd1,
    STS_NORUN = 2'd2,
    STS_BAD   = 2'd3
  } status_e;

  typedef enum logic {
    CFG_FRAME_COUNT = 1'b0,
    CFG_RESERVED    = 1'b1
  } cfg_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_FF_RD, S_FF_EV, S_AL_WR, S_VM, S_VC_RD, S_VC_EV,
    S_VP, S_EV_EM, S_R1_RD, S_R1_EV, S_R2_RD, S_R2_EV, S_W_RD, S_W_EV, S_W_EM,
    S_CHK_RD, S_CHK_EV, S_KH_RD, S_KH_EV, S_KF_RD, S_KF_EV, S_KF_CLR, S_DONE
  } seq_e;

  typedef struct packed {
    fstate_e     st;
    logic [4:0]  run;
    logic [15:0] owner;
    logic [19:0] vpage;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [9:0]  frame;
    logic [15:0] owner;
    logic [19:0] vpage;
    logic        wb;
    status_e     status;
    logic        last;
  } res_t;

endpackage

/* sv/pfa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pfa_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_alu: shared subtract and compare unit
// Gives a - b and a >= b; used step by step for modulo reduction.
// ----------------------------------------------------------------------------
module pfa_alu (
  input  logic [pfa_pkg::CW-1:0] a_i,
  input  logic [pfa_pkg::CW-1:0] b_i,
  output logic [pfa_pkg::CW-1:0] diff_o,
  output logic                   ge_o
);

  logic [pfa_pkg::CW:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = sub[pfa_pkg::CW-1:0];
  assign ge_o   = ~sub[pfa_pkg::CW];

endmodule

/* sv/pfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ctrl: command sequencer of the page frame allocator
// Walks the frame table one entry per step and produces result words.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             cmd_i,
  input  logic [4:0]             page_count_i,
  input  logic [9:0]             frame_index_i,
  input  logic [15:0]            owner_id_i,
  input  logic [19:0]            virtual_page_i,
  input  logic [pfa_pkg::CW-1:0] n_i,
  input  logic [pfa_pkg::CW-1:0] rsv_i,
  input  logic                   slot_free_i,
  output pfa_pkg::res_t          res_o
);

  localparam int AW = pfa_pkg::AW;
  localparam int CW = pfa_pkg::CW;

  pfa_pkg::seq_e   st_q, st_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [4:0]      np_q, np_d;
  logic [9:0]      fi_q, fi_d;
  logic [15:0]     own_q, own_d;
  logic [19:0]     vpg_q, vpg_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   k_q, k_d;
  logic [4:0]      run_q, run_d;
  logic [CW-1:0]   end_q, end_d;
  logic [AW-1:0]   base_q, base_d;
  logic [AW-1:0]   vp_q, vp_d;
  logic [CW-1:0]   x_q, x_d;
  pfa_pkg::entry_t ent_q, ent_d;
  pfa_pkg::status_e sts_q, sts_d;
  logic [AW-1:0]   frm_q, frm_d;
  logic            init_q, init_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  pfa_pkg::entry_t wdata, rdata, newval;
  logic [CW-1:0]   alu_diff;
  logic            alu_ge;
  logic [CW-1:0]   idx_inc, idx_wrap, x_inc;
  logic [4:0]      nr_free, nr_nfix;
  logic            idx_lt_n, idx_at_end, np_bad, kh_bad, victim_ok;

  pfa_ram #(.W($bits(pfa_pkg::entry_t)), .D(pfa_pkg::MAX_FRAMES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pfa_alu u_alu (
    .a_i    (x_q),
    .b_i    (n_i),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  assign idx_inc    = idx_q + CW'(1);
  assign idx_wrap   = (idx_inc == n_i) ? '0 : idx_inc;
  assign x_inc      = (x_q + CW'(1) == n_i) ? '0 : x_q + CW'(1);
  assign idx_lt_n   = idx_q < n_i;
  assign idx_at_end = idx_q == end_q;
  assign nr_free    = (rdata.st == pfa_pkg::FS_FREE) ? run_q + 5'd1 : 5'd0;
  assign nr_nfix    = (rdata.st != pfa_pkg::FS_FIXED) ? run_q + 5'd1 : 5'd0;
  assign np_bad     = (np_q == 5'd0) || (np_q > 5'(pfa_pkg::MAX_RUN));
  assign kh_bad     = (rdata.run == 5'd0) ||
                      ((CW+1)'(fi_q) + (CW+1)'(rdata.run) > (CW+1)'(n_i));
  assign victim_ok  = (rdata.st == pfa_pkg::FS_CLEAN) || (rdata.st == pfa_pkg::FS_DIRTY);
  assign in_stall_o = st_q != pfa_pkg::S_IDLE;

  always_comb begin
    newval = '0;
    newval.run = 5'd1;
    if (cmd_q == pfa_pkg::CMD_UALLOC) begin
      newval.st    = pfa_pkg::FS_DIRTY;
      newval.owner = own_q;
      newval.vpage = vpg_q;
    end else begin
      newval.st = pfa_pkg::FS_FIXED;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      pfa_pkg::S_CLR: begin
        if (idx_q[AW-1:0] == AW'(pfa_pkg::MAX_FRAMES - 1)) begin
          st_d = init_q ? pfa_pkg::S_DONE : pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          st_d = pfa_pkg::S_DEC;
        end
      end
      pfa_pkg::S_DEC: begin
        case (cmd_q)
          pfa_pkg::CMD_INIT: st_d = pfa_pkg::S_CLR;
          pfa_pkg::CMD_KALLOC: begin
            if (np_bad) begin
              st_d = pfa_pkg::S_DONE;
            end else if (np_q == 5'd1) begin
              st_d = pfa_pkg::S_FF_RD;
            end else begin
              st_d = pfa_pkg::S_R1_RD;
            end
          end
          pfa_pkg::CMD_UALLOC: st_d = pfa_pkg::S_FF_RD;
          pfa_pkg::CMD_UFREE, pfa_pkg::CMD_CLEAN: begin
            st_d = (CW'(fi_q) >= n_i) ? pfa_pkg::S_DONE : pfa_pkg::S_CHK_RD;
          end
          pfa_pkg::CMD_KFREE: begin
            if (CW'(fi_q) < rsv_i || CW'(fi_q) >= n_i) begin
              st_d = pfa_pkg::S_DONE;
            end else begin
              st_d = pfa_pkg::S_KH_RD;
            end
          end
          default: st_d = pfa_pkg::S_DONE;
        endcase
      end
      pfa_pkg::S_FF_RD: st_d = idx_lt_n ? pfa_pkg::S_FF_EV : pfa_pkg::S_VM;
      pfa_pkg::S_FF_EV: begin
        st_d = (rdata.st == pfa_pkg::FS_FREE) ? pfa_pkg::S_AL_WR : pfa_pkg::S_FF_RD;
      end
      pfa_pkg::S_AL_WR: st_d = pfa_pkg::S_DONE;
      pfa_pkg::S_VM: begin
        if (n_i == '0) begin
          st_d = pfa_pkg::S_DONE;
        end else if (!alu_ge) begin
          st_d = pfa_pkg::S_VC_RD;
        end
      end
      pfa_pkg::S_VC_RD: st_d = (k_q >= n_i) ? pfa_pkg::S_DONE : pfa_pkg::S_VC_EV;
      pfa_pkg::S_VC_EV: st_d = victim_ok ? pfa_pkg::S_VP : pfa_pkg::S_VC_RD;
      pfa_pkg::S_VP: begin
        if (!alu_ge) begin
          if (cmd_q == pfa_pkg::CMD_KALLOC && np_q != 5'd1) begin
            st_d = pfa_pkg::S_R2_RD;
          end else begin
            st_d = pfa_pkg::S_EV_EM;
          end
        end
      end
      pfa_pkg::S_EV_EM: if (slot_free_i) st_d = pfa_pkg::S_DONE;
      pfa_pkg::S_R1_RD: st_d = idx_lt_n ? pfa_pkg::S_R1_EV : pfa_pkg::S_VM;
      pfa_pkg::S_R1_EV: st_d = (nr_free == np_q) ? pfa_pkg::S_W_RD : pfa_pkg::S_R1_RD;
      pfa_pkg::S_R2_RD: st_d = idx_lt_n ? pfa_pkg::S_R2_EV : pfa_pkg::S_DONE;
      pfa_pkg::S_R2_EV: st_d = (nr_nfix == np_q) ? pfa_pkg::S_W_RD : pfa_pkg::S_R2_RD;
      pfa_pkg::S_W_RD: st_d = pfa_pkg::S_W_EV;
      pfa_pkg::S_W_EV: begin
        if (rdata.st != pfa_pkg::FS_FREE) begin
          st_d = pfa_pkg::S_W_EM;
        end else begin
          st_d = idx_at_end ? pfa_pkg::S_DONE : pfa_pkg::S_W_RD;
        end
      end
      pfa_pkg::S_W_EM: begin
        if (slot_free_i) begin
          st_d = idx_at_end ? pfa_pkg::S_DONE : pfa_pkg::S_W_RD;
        end
      end
      pfa_pkg::S_CHK_RD: st_d = pfa_pkg::S_CHK_EV;
      pfa_pkg::S_CHK_EV: st_d = pfa_pkg::S_DONE;
      pfa_pkg::S_KH_RD: st_d = pfa_pkg::S_KH_EV;
      pfa_pkg::S_KH_EV: st_d = kh_bad ? pfa_pkg::S_DONE : pfa_pkg::S_KF_RD;
      pfa_pkg::S_KF_RD: st_d = pfa_pkg::S_KF_EV;
      pfa_pkg::S_KF_EV: begin
        if (rdata.st != pfa_pkg::FS_FIXED) begin
          st_d = pfa_pkg::S_DONE;
        end else if (idx_at_end) begin
          st_d = pfa_pkg::S_KF_CLR;
        end else begin
          st_d = pfa_pkg::S_KF_RD;
        end
      end
      pfa_pkg::S_KF_CLR: if (idx_at_end) st_d = pfa_pkg::S_DONE;
      pfa_pkg::S_DONE: if (slot_free_i) st_d = pfa_pkg::S_IDLE;
      default: st_d = pfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d  = cmd_q;
    np_d   = np_q;
    fi_d   = fi_q;
    own_d  = own_q;
    vpg_d  = vpg_q;
    idx_d  = idx_q;
    k_d    = k_q;
    run_d  = run_q;
    end_d  = end_q;
    base_d = base_q;
    vp_d   = vp_q;
    x_d    = x_q;
    ent_d  = ent_q;
    sts_d  = sts_q;
    frm_d  = frm_q;
    init_d = init_q;
    we     = 1'b0;
    waddr  = idx_q[AW-1:0];
    wdata  = '0;
    raddr  = idx_q[AW-1:0];
    res_o  = '0;
    case (st_q)
      pfa_pkg::S_CLR: begin
        we = 1'b1;
        if (init_q && idx_lt_n && idx_q < rsv_i) begin
          wdata.st = pfa_pkg::FS_FIXED;
        end
        idx_d = idx_inc;
        vp_d  = '0;
        sts_d = pfa_pkg::STS_OK;
        frm_d = '0;
      end
      pfa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          np_d  = page_count_i;
          fi_d  = frame_index_i;
          own_d = owner_id_i;
          vpg_d = virtual_page_i;
        end
        idx_d  = '0;
        run_d  = '0;
        x_d    = CW'(vp_q);
        sts_d  = pfa_pkg::STS_OK;
        frm_d  = '0;
        init_d = 1'b0;
      end
      pfa_pkg::S_DEC: begin
        case (cmd_q)
          pfa_pkg::CMD_INIT: init_d = 1'b1;
          pfa_pkg::CMD_KALLOC: if (np_bad) sts_d = pfa_pkg::STS_BAD;
          pfa_pkg::CMD_UALLOC: sts_d = pfa_pkg::STS_OK;
          pfa_pkg::CMD_UFREE, pfa_pkg::CMD_CLEAN: begin
            if (CW'(fi_q) >= n_i) sts_d = pfa_pkg::STS_BAD;
          end
          pfa_pkg::CMD_KFREE: begin
            if (CW'(fi_q) < rsv_i) begin
              frm_d = fi_q;
            end else if (CW'(fi_q) >= n_i) begin
              sts_d = pfa_pkg::STS_BAD;
            end
          end
          default: sts_d = pfa_pkg::STS_BAD;
        endcase
      end
      pfa_pkg::S_FF_EV: begin
        if (rdata.st == pfa_pkg::FS_FREE) begin
          base_d = idx_q[AW-1:0];
        end else begin
          idx_d = idx_inc;
        end
      end
      pfa_pkg::S_AL_WR: begin
        we    = 1'b1;
        waddr = base_q;
        wdata = newval;
        frm_d = base_q;
      end
      pfa_pkg::S_VM: begin
        if (n_i == '0) begin
          sts_d = pfa_pkg::STS_OOM;
        end else if (alu_ge) begin
          x_d = alu_diff;
        end else begin
          idx_d = x_inc;
          k_d   = CW'(1);
        end
      end
      pfa_pkg::S_VC_RD: if (k_q >= n_i) sts_d = pfa_pkg::STS_OOM;
      pfa_pkg::S_VC_EV: begin
        ent_d = rdata;
        if (victim_ok) begin
          base_d = idx_q[AW-1:0];
          x_d    = idx_q + CW'(pfa_pkg::VICTIM_STRIDE);
        end else begin
          idx_d = idx_wrap;
          k_d   = k_q + CW'(1);
        end
      end
      pfa_pkg::S_VP: begin
        if (alu_ge) begin
          x_d = alu_diff;
        end else begin
          vp_d  = x_q[AW-1:0];
          idx_d = CW'(base_q);
          run_d = '0;
        end
      end
      pfa_pkg::S_EV_EM: begin
        res_o.valid = 1'b1;
        res_o.frame = base_q;
        res_o.owner = ent_q.owner;
        res_o.vpage = ent_q.vpage;
        res_o.wb    = ent_q.st == pfa_pkg::FS_DIRTY;
        if (slot_free_i) begin
          we    = 1'b1;
          waddr = base_q;
          wdata = newval;
          frm_d = base_q;
        end
      end
      pfa_pkg::S_R1_EV, pfa_pkg::S_R2_EV: begin
        run_d = (st_q == pfa_pkg::S_R1_EV) ? nr_free : nr_nfix;
        if (run_d == np_q) begin
          end_d  = idx_q;
          idx_d  = idx_inc - CW'(np_q);
          base_d = AW'(idx_inc - CW'(np_q));
        end else begin
          idx_d = idx_inc;
        end
      end
      pfa_pkg::S_R2_RD: if (!idx_lt_n) sts_d = pfa_pkg::STS_NORUN;
      pfa_pkg::S_W_EV, pfa_pkg::S_W_EM: begin
        if (st_q == pfa_pkg::S_W_EV) begin
          ent_d = rdata;
        end else begin
          res_o.valid = 1'b1;
          res_o.frame = idx_q[AW-1:0];
          res_o.owner = ent_q.owner;
          res_o.vpage = ent_q.vpage;
          res_o.wb    = ent_q.st == pfa_pkg::FS_DIRTY;
        end
        wdata.st  = pfa_pkg::FS_FIXED;
        wdata.run = (idx_q[AW-1:0] == base_q) ? np_q : 5'd0;
        frm_d     = base_q;
        if ((st_q == pfa_pkg::S_W_EV && rdata.st == pfa_pkg::FS_FREE) ||
            (st_q == pfa_pkg::S_W_EM && slot_free_i)) begin
          we    = 1'b1;
          idx_d = idx_inc;
        end
      end
      pfa_pkg::S_CHK_RD: raddr = fi_q;
      pfa_pkg::S_CHK_EV: begin
        waddr = fi_q;
        if (rdata.st == pfa_pkg::FS_FREE || rdata.st == pfa_pkg::FS_FIXED) begin
          sts_d = pfa_pkg::STS_BAD;
        end else begin
          we    = 1'b1;
          frm_d = fi_q;
          if (cmd_q == pfa_pkg::CMD_CLEAN) begin
            wdata    = rdata;
            wdata.st = pfa_pkg::FS_CLEAN;
          end
        end
      end
      pfa_pkg::S_KH_RD: raddr = fi_q;
      pfa_pkg::S_KH_EV: begin
        if (kh_bad) begin
          sts_d = pfa_pkg::STS_BAD;
        end else begin
          idx_d = CW'(fi_q);
          end_d = CW'(fi_q) + CW'(rdata.run) - CW'(1);
        end
      end
      pfa_pkg::S_KF_EV: begin
        if (rdata.st != pfa_pkg::FS_FIXED) begin
          sts_d = pfa_pkg::STS_BAD;
        end else if (idx_at_end) begin
          idx_d = CW'(fi_q);
        end else begin
          idx_d = idx_inc;
        end
      end
      pfa_pkg::S_KF_CLR: begin
        we    = 1'b1;
        idx_d = idx_inc;
        frm_d = fi_q;
      end
      pfa_pkg::S_DONE: begin
        res_o.valid  = 1'b1;
        res_o.kind   = 1'b1;
        res_o.frame  = (sts_q == pfa_pkg::STS_OK) ? frm_q : '0;
        res_o.status = sts_q;
        res_o.last   = 1'b1;
      end
      default: begin
        raddr = idx_q[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= pfa_pkg::S_CLR;
      idx_q  <= '0;
      k_q    <= '0;
      run_q  <= '0;
      vp_q   <= '0;
      x_q    <= '0;
      sts_q  <= pfa_pkg::STS_OK;
      init_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      k_q    <= k_d;
      run_q  <= run_d;
      vp_q   <= vp_d;
      x_q    <= x_d;
      sts_q  <= sts_d;
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    np_q   <= np_d;
    fi_q   <= fi_d;
    own_q  <= own_d;
    vpg_q  <= vpg_d;
    end_q  <= end_d;
    base_q <= base_d;
    ent_q  <= ent_d;
    frm_q  <= frm_d;
  end

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == pfa_pkg::S_IDLE |-> !res_o.valid)
    else $error("result offered while idle");
  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.last |-> res_o.kind)
    else $error("last word is not a completion");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == pfa_pkg::S_IDLE && in_valid_i |=> st_q == pfa_pkg::S_DEC)
    else $error("accepted word not decoded");
  a_clear_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == pfa_pkg::S_CLR |-> we)
    else $error("clearing pass skipped a write");
`endif

endmodule

/* sv/page_frame_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator: first-fit page frame allocator
// Frame table with kernel and user allocation, frees and victim eviction.
// ----------------------------------------------------------------------------
// Usage: a command word enters on the input channel (in_valid_i, in_stall_o).
// Results leave on the output channel (out_valid_o, out_stall_i): zero or
// more eviction notices and then one completion word with last_o set.
// Configuration is written through cfg_valid_i/cfg_ready_o while idle; this
// binds the user, as the block itself does not enforce it. The frame table
// sits in one RAM with registered read, and the sequencer looks at one
// entry per pair of read and evaluate states. A command is shortest for a
// user free, a mark clean or an error, and longest for a run allocation
// that scans, searches a victim and scans again; a victim pointer
// reduction takes one subtraction per step. Init writes every entry.
// One command is processed at a time. After reset the whole table is
// cleared, during which no command is accepted. A stalled output word holds;
// the sequencer waits for the output register before producing the next word.
// ----------------------------------------------------------------------------
module page_frame_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [4:0]  page_count_i,
  input  logic [9:0]  frame_index_i,
  input  logic [15:0] owner_id_i,
  input  logic [19:0] virtual_page_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [9:0]  frame_o,
  output logic [15:0] victim_owner_o,
  output logic [19:0] victim_page_o,
  output logic        needs_writeback_o,
  output logic [1:0]  status_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int CW = pfa_pkg::CW;

  logic [10:0]    fc_q, rs_q;
  logic [CW-1:0]  n_w;
  logic           out_valid_q, out_valid_d, slot_free;
  pfa_pkg::res_t  out_q, res;

  assign cfg_ready_o = 1'b1;
  assign n_w = (fc_q > 11'(pfa_pkg::MAX_FRAMES)) ? CW'(pfa_pkg::MAX_FRAMES) : CW'(fc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= 11'(pfa_pkg::MAX_FRAMES);
      rs_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pfa_pkg::CFG_FRAME_COUNT) begin
        fc_q <= cfg_data_i;
      end else begin
        rs_q <= cfg_data_i;
      end
    end
  end

  pfa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .page_count_i   (page_count_i),
    .frame_index_i  (frame_index_i),
    .owner_id_i     (owner_id_i),
    .virtual_page_i (virtual_page_i),
    .n_i            (n_w),
    .rsv_i          (CW'(rs_q)),
    .slot_free_i    (slot_free),
    .res_o          (res)
  );

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res.valid && slot_free) ? 1'b1 : (slot_free ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && slot_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign frame_o           = out_q.frame;
  assign victim_owner_o    = out_q.owner;
  assign victim_page_o     = out_q.vpage;
  assign needs_writeback_o = out_q.wb;
  assign status_o          = out_q.status;
  assign last_o            = out_q.last;

endmodule
